>>> src/mvcs_pkg.sv
// Shared types and constants for the motion vector cost selection block.
package mvcs_pkg;

  // Fixed field widths
  localparam int VEC_W       = 16;
  localparam int RES_W       = 16;
  localparam int LAMBDA_W    = 16;
  localparam int COST_W      = 22;
  localparam int MV_BITS_DEF = 16;

  // Pipeline depth: diff, multiply, leading one, cost, select
  localparam int NSTAGE = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA = 1'b0,
    CFG_WEAK   = 1'b1
  } cfg_idx_e;

  // One candidate vector with its residual
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [RES_W-1:0]        res;
  } cand_t;

  // The three candidates of one position
  typedef struct packed {
    cand_t near;
    cand_t wide;
    cand_t free;
  } cand_set_t;

  // Stage load enables for the lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_adv_t;

  // Stage load enables for the merge stages
  typedef struct packed {
    logic cost;
    logic sel;
  } merge_adv_t;

endpackage

>>> src/mvcs_lane.sv
// One bit-estimate lane: |difference|, product and highest set bit.
module mvcs_lane #(
  parameter int MV_BITS = mvcs_pkg::MV_BITS_DEF,
  localparam int BITS_W = $clog2(2 * MV_BITS + 1)
) (
  input  logic                                 clk_i,
  input  mvcs_pkg::lane_adv_t                  adv_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    cand_x_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    cand_y_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    ref_x_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    ref_y_i,
  output logic [BITS_W-1:0]                    bits_o
);

  localparam int AW = MV_BITS + 1;
  localparam int PW = 2 * AW;

  logic signed [mvcs_pkg::VEC_W:0] dx, dy;
  logic [MV_BITS-1:0] mx, my;
  logic [AW-1:0] ax_d, ay_d, ax_q, ay_q;
  logic [PW-1:0] prod_d, prod_q;
  logic [BITS_W-1:0] bits_d, bits_q;

  // Stage 1: magnitudes of the differences, plus one
  always_comb begin
    dx = {cand_x_i[mvcs_pkg::VEC_W-1], cand_x_i} - {ref_x_i[mvcs_pkg::VEC_W-1], ref_x_i};
    dy = {cand_y_i[mvcs_pkg::VEC_W-1], cand_y_i} - {ref_y_i[mvcs_pkg::VEC_W-1], ref_y_i};
    mx = dx[mvcs_pkg::VEC_W] ? MV_BITS'(-dx) : MV_BITS'(dx);
    my = dy[mvcs_pkg::VEC_W] ? MV_BITS'(-dy) : MV_BITS'(dy);
    ax_d = {1'b0, mx} + AW'(1);
    ay_d = {1'b0, my} + AW'(1);
  end

  // Stage 2: exact product
  assign prod_d = PW'(ax_q) * PW'(ay_q);

  // Stage 3: index of the highest set bit (product is never zero)
  always_comb begin
    bits_d = '0;
    for (int i = 0; i < PW; i++) begin
      if (prod_q[i]) bits_d = BITS_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
    if (adv_i.s2) prod_q <= prod_d;
    if (adv_i.s3) bits_q <= bits_d;
  end

  assign bits_o = bits_q;

endmodule

>>> src/mvcs_merge.sv
// Merge stages: candidate costs, then the nested comparison into the output register.
module mvcs_merge #(
  parameter int MV_BITS = mvcs_pkg::MV_BITS_DEF,
  localparam int BITS_W = $clog2(2 * MV_BITS + 1)
) (
  input  logic                                 clk_i,
  input  mvcs_pkg::merge_adv_t                 adv_i,
  input  logic [mvcs_pkg::LAMBDA_W-1:0]        lambda_i,
  input  logic                                 weak_i,
  input  mvcs_pkg::cand_set_t                  cands_i,
  input  logic [BITS_W-1:0]                    bits_n_i,
  input  logic [BITS_W-1:0]                    bits_w_i,
  input  logic [BITS_W-1:0]                    bits_fp_i,
  input  logic [BITS_W-1:0]                    bits_f0_i,
  output logic signed [mvcs_pkg::VEC_W-1:0]    best_x_o,
  output logic signed [mvcs_pkg::VEC_W-1:0]    best_y_o,
  output logic [mvcs_pkg::COST_W-1:0]          best_cost_o
);

  localparam int SW = mvcs_pkg::LAMBDA_W + BITS_W + 1;

  logic [BITS_W-1:0] bits_f;
  logic [mvcs_pkg::COST_W-1:0] cn_d, cw_d, cf_d, cn_q, cw_q, cf_q;
  mvcs_pkg::cand_set_t c_q;
  logic signed [mvcs_pkg::VEC_W-1:0] bx_d, by_d, bx_q, by_q;
  logic [mvcs_pkg::COST_W-1:0] bc_d, bc_q;

  // Cost stage: free candidate takes the smaller of its two estimates
  always_comb begin
    bits_f = (bits_f0_i < bits_fp_i) ? bits_f0_i : bits_fp_i;
    cn_d = mvcs_pkg::COST_W'(SW'(cands_i.near.res) + SW'(lambda_i) * SW'(bits_n_i));
    cw_d = mvcs_pkg::COST_W'(SW'(cands_i.wide.res) + SW'(lambda_i) * SW'(bits_w_i));
    cf_d = mvcs_pkg::COST_W'(SW'(cands_i.free.res) + SW'(lambda_i) * SW'(bits_f));
  end

  // Select stage: nested comparison in full mode, plain compare in weak mode
  always_comb begin
    bx_d = c_q.near.x;
    by_d = c_q.near.y;
    bc_d = cn_q;
    if (weak_i) begin
      if (cn_q > cw_q) begin
        bx_d = c_q.wide.x;
        by_d = c_q.wide.y;
        bc_d = cw_q;
      end
    end else if (cn_q > cf_q) begin
      if (cf_q > cw_q) begin
        bx_d = c_q.wide.x;
        by_d = c_q.wide.y;
        bc_d = cw_q;
      end else begin
        bx_d = c_q.free.x;
        by_d = c_q.free.y;
        bc_d = cf_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.cost) begin
      cn_q <= cn_d;
      cw_q <= cw_d;
      cf_q <= cf_d;
      c_q  <= cands_i;
    end
    if (adv_i.sel) begin
      bx_q <= bx_d;
      by_q <= by_d;
      bc_q <= bc_d;
    end
  end

  assign best_x_o    = bx_q;
  assign best_y_o    = by_q;
  assign best_cost_o = bc_q;

endmodule

>>> src/motion_vector_cost_select_top.sv
// Top level of the motion vector cost selection block.
// Takes one vector position per clock while in_stall_o is low and returns the
// chosen vector and its cost from the output register. Four bit-estimate lanes
// (near, wide, free against the predictor, free against zero) run side by
// side through a three-stage pipeline (difference, 17x17 multiply, highest
// set bit); a cost stage and a select stage follow, the latter being the
// output register. Every stage holds only while the stage after it is full
// and blocked, so in_stall_o rises only when all five stages hold data and
// out_stall_i is high. The user must write lambda and weak_mode through the
// cfg port only while no transaction is in flight; the block does not enforce it.
module motion_vector_cost_select_top #(
  parameter int MV_BITS = mvcs_pkg::MV_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [mvcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mvcs_pkg::LAMBDA_W-1:0]        cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    pred_x_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    pred_y_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    near_x_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    near_y_i,
  input  logic [mvcs_pkg::RES_W-1:0]           near_residual_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    wide_x_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    wide_y_i,
  input  logic [mvcs_pkg::RES_W-1:0]           wide_residual_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    free_x_i,
  input  logic signed [mvcs_pkg::VEC_W-1:0]    free_y_i,
  input  logic [mvcs_pkg::RES_W-1:0]           free_residual_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mvcs_pkg::VEC_W-1:0]    best_x_o,
  output logic signed [mvcs_pkg::VEC_W-1:0]    best_y_o,
  output logic [mvcs_pkg::COST_W-1:0]          best_cost_o
);

  localparam int BITS_W = $clog2(2 * MV_BITS + 1);
  localparam int NS = mvcs_pkg::NSTAGE;

  // Low MV_BITS bits of a component, sign-extended
  function automatic logic signed [mvcs_pkg::VEC_W-1:0] sx(
    input logic [mvcs_pkg::VEC_W-1:0] v
  );
    logic signed [MV_BITS-1:0] t;
    t = v[MV_BITS-1:0];
    return mvcs_pkg::VEC_W'(t);
  endfunction

  logic [mvcs_pkg::LAMBDA_W-1:0] lambda_q;
  logic weak_q;
  logic [NS-1:0] v_d, v_q, adv;
  mvcs_pkg::cand_set_t c1_d, c1_q, c2_q, c3_q;
  logic signed [mvcs_pkg::VEC_W-1:0] ref_x, ref_y;
  mvcs_pkg::lane_adv_t lane_adv;
  mvcs_pkg::merge_adv_t merge_adv;
  logic [BITS_W-1:0] bits_n, bits_w, bits_fp, bits_f0;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= '0;
      weak_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (mvcs_pkg::cfg_idx_e'(cfg_idx_i))
        mvcs_pkg::CFG_LAMBDA: lambda_q <= cfg_wdata_i;
        mvcs_pkg::CFG_WEAK:   weak_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when empty or when the next one moves
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NS-1];

  assign lane_adv  = '{s1: adv[0], s2: adv[1], s3: adv[2]};
  assign merge_adv = '{cost: adv[3], sel: adv[4]};

  // Candidate capture; predictor reads as zero in weak mode
  always_comb begin
    c1_d.near = '{x: sx(near_x_i), y: sx(near_y_i), res: near_residual_i};
    c1_d.wide = '{x: sx(wide_x_i), y: sx(wide_y_i), res: wide_residual_i};
    c1_d.free = '{x: sx(free_x_i), y: sx(free_y_i), res: free_residual_i};
    ref_x = weak_q ? '0 : sx(pred_x_i);
    ref_y = weak_q ? '0 : sx(pred_y_i);
  end

  // Candidates ride along with the lane pipeline
  always_ff @(posedge clk_i) begin
    if (adv[0]) c1_q <= c1_d;
    if (adv[1]) c2_q <= c1_q;
    if (adv[2]) c3_q <= c2_q;
  end

  mvcs_lane #(.MV_BITS(MV_BITS)) u_lane_near (
    .clk_i    (clk_i),
    .adv_i    (lane_adv),
    .cand_x_i (c1_d.near.x),
    .cand_y_i (c1_d.near.y),
    .ref_x_i  (ref_x),
    .ref_y_i  (ref_y),
    .bits_o   (bits_n)
  );

  mvcs_lane #(.MV_BITS(MV_BITS)) u_lane_wide (
    .clk_i    (clk_i),
    .adv_i    (lane_adv),
    .cand_x_i (c1_d.wide.x),
    .cand_y_i (c1_d.wide.y),
    .ref_x_i  (ref_x),
    .ref_y_i  (ref_y),
    .bits_o   (bits_w)
  );

  mvcs_lane #(.MV_BITS(MV_BITS)) u_lane_free_pred (
    .clk_i    (clk_i),
    .adv_i    (lane_adv),
    .cand_x_i (c1_d.free.x),
    .cand_y_i (c1_d.free.y),
    .ref_x_i  (ref_x),
    .ref_y_i  (ref_y),
    .bits_o   (bits_fp)
  );

  mvcs_lane #(.MV_BITS(MV_BITS)) u_lane_free_zero (
    .clk_i    (clk_i),
    .adv_i    (lane_adv),
    .cand_x_i (c1_d.free.x),
    .cand_y_i (c1_d.free.y),
    .ref_x_i  ('0),
    .ref_y_i  ('0),
    .bits_o   (bits_f0)
  );

  mvcs_merge #(.MV_BITS(MV_BITS)) u_merge (
    .clk_i       (clk_i),
    .adv_i       (merge_adv),
    .lambda_i    (lambda_q),
    .weak_i      (weak_q),
    .cands_i     (c3_q),
    .bits_n_i    (bits_n),
    .bits_w_i    (bits_w),
    .bits_fp_i   (bits_fp),
    .bits_f0_i   (bits_f0),
    .best_x_o    (best_x_o),
    .best_y_o    (best_y_o),
    .best_cost_o (best_cost_o)
  );

endmodule

>>> src/mvcs_checker.sv
// Port-level checker for the motion vector cost selection block, with its bind.
module mvcs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [mvcs_pkg::VEC_W-1:0] best_x_o,
  input logic signed [mvcs_pkg::VEC_W-1:0] best_y_o,
  input logic [mvcs_pkg::COST_W-1:0]       best_cost_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(best_x_o) && $stable(best_y_o)
      && $stable(best_cost_o))
    else $error("stalled result changed");

  // Input back-pressure only comes from a blocked output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // An accepted transaction reaches the output when out_stall_i stays low in between
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind motion_vector_cost_select_top mvcs_checker u_mvcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .best_x_o    (best_x_o),
  .best_y_o    (best_y_o),
  .best_cost_o (best_cost_o)
);
